// ----- src/tcw_pkg.sv -----
// Package for the text console writer: action codes, control state encoding,
// character codes and the put-control struct. No dependencies.
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int DATA_W     = 16;
    localparam int IDX_W      = 11;
    localparam int COL_PORT_W = 7;
    localparam int ROW_PORT_W = 5;
    localparam int CHAR_W     = 8;
    localparam int COLOR_W    = 4;
    localparam int CFG_IDX_W  = 2;

    localparam logic [DATA_W-1:0] BLANK_CELL = 16'h0F20;

    localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_DEL   = 8'h7F;

    localparam logic [CFG_IDX_W-1:0] REG_BACK_COLOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FORE_COLOR = 2'd1;

    typedef enum logic [1:0] {
        ACT_PUT   = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_BLANK,
        ST_RDWAIT,
        ST_RESP
    } tcw_state_t;

    typedef struct packed {
        logic write_cell;
        logic row_inc;
    } put_ctl_t;

endpackage

// ----- src/text_console_writer.sv -----
// Top level of the text console writer: request decode, control sequencer,
// cursor and scroll state. Depends on tcw_pkg, tcw_cell_ram, tcw_cursor_unit.
`timescale 1ns / 1ps
//
// Usage:
//   s_* channel takes one request: put a byte, clear the screen or read a cell.
//   m_* channel returns exactly one result per request: read data (zero unless
//   a read) and the cursor position after the request.
//   cfg_* channel writes back_color (index 0) and fore_color (index 1); it is
//   always ready; write it only while no request is in flight.
// Sequence, request accept to result valid:
//   every request passes ST_EXEC and ST_RESP; a put that scrolls adds ST_BLANK
//   over one row, an in-range read adds ST_RDWAIT, and a clear adds ST_BLANK over
//   every cell. A new request is taken in the cycle after the result is loaded,
//   so requests are worked on one at a time.
//   Scroll moves a top-row pointer into the cell memory and blanks one row
//   through its single write port; clear sweeps every cell through that port.
// Reset: cursor homes, colors return to black background, white foreground,
//   and a clearing pass over all COLUMNS*ROWS cells (2000 by default) blanks
//   them while s_ready stays low.
// Stall: the result sits in an output register; the next request is still
//   accepted and worked on, and its result waits until m_ready frees it.

module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_action,
    input  logic [CHAR_W-1:0]     s_char_code,
    input  logic [IDX_W-1:0]      s_cell_index,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [DATA_W-1:0]     m_read_data,
    output logic [COL_PORT_W-1:0] m_cursor_col,
    output logic [ROW_PORT_W-1:0] m_cursor_row,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [COLOR_W-1:0]    cfg_wdata
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int AW = $clog2(CELL_COUNT);
    localparam int CW = $clog2(COLUMNS);
    localparam int RW = $clog2(ROWS);
    localparam int PW = $clog2(TAB_STOP);
    localparam int SW = ((AW > IDX_W) ? AW : IDX_W) + 1;
    localparam int OCW = (CW > COL_PORT_W) ? CW : COL_PORT_W;
    localparam int ORW = (RW > ROW_PORT_W) ? RW : ROW_PORT_W;

    localparam logic [AW:0]   CELL_COUNT_W = (AW + 1)'(CELL_COUNT);
    localparam logic [AW-1:0] COL_STEP     = AW'(COLUMNS);
    localparam logic [AW-1:0] ROW_SPAN     = AW'(COLUMNS - 1);
    localparam logic [AW-1:0] LAST_CELL    = AW'(CELL_COUNT - 1);
    localparam logic [RW-1:0] ROW_LAST     = RW'(ROWS - 1);

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                               input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= CELL_COUNT_W) begin
            s = s - CELL_COUNT_W;
        end
        return s[AW-1:0];
    endfunction

    tcw_state_t state_reg, state_next;

    action_t             action_reg, action_next;
    logic [CHAR_W-1:0]   char_reg, char_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [CW-1:0]       col_reg, col_next;
    logic [PW-1:0]       phase_reg, phase_next;
    logic [RW-1:0]       row_reg, row_next;
    logic [AW-1:0]       top_base_reg, top_base_next;
    logic [AW-1:0]       row_base_reg, row_base_next;
    logic [AW-1:0]       blank_addr_reg, blank_addr_next;
    logic [AW-1:0]       blank_last_reg, blank_last_next;
    logic [DATA_W-1:0]   resp_data_reg, resp_data_next;
    logic [COLOR_W-1:0]  back_reg, back_next;
    logic [COLOR_W-1:0]  fore_reg, fore_next;

    logic                  m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]     m_read_data_reg, m_read_data_next;
    logic [COL_PORT_W-1:0] m_cursor_col_reg, m_cursor_col_next;
    logic [ROW_PORT_W-1:0] m_cursor_row_reg, m_cursor_row_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [DATA_W-1:0] ram_rdata;

    logic [CW-1:0] put_col;
    logic [PW-1:0] put_phase;
    put_ctl_t      put_ctl;

    logic [SW-1:0]  idx_wide;
    logic           idx_in_range;
    logic [AW-1:0]  rd_addr;
    logic [AW-1:0]  wr_addr;
    logic [OCW-1:0] col_out;
    logic [ORW-1:0] row_out;

    tcw_cell_ram #(
        .DEPTH (CELL_COUNT),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    tcw_cursor_unit #(
        .COLUMNS  (COLUMNS),
        .TAB_STOP (TAB_STOP),
        .CW       (CW),
        .PW       (PW)
    ) u_cursor (
        .char_code  (char_reg),
        .col        (col_reg),
        .phase      (phase_reg),
        .next_col   (put_col),
        .next_phase (put_phase),
        .ctl        (put_ctl)
    );

    assign idx_wide     = SW'(idx_reg);
    assign idx_in_range = idx_wide < SW'(CELL_COUNT);
    assign rd_addr      = wrap_add(top_base_reg, idx_wide[AW-1:0]);
    assign wr_addr      = wrap_add(row_base_reg, AW'(col_reg));
    assign col_out      = OCW'(col_reg);
    assign row_out      = ORW'(row_reg);

    assign cfg_ready    = 1'b1;
    assign m_valid      = m_valid_reg;
    assign m_read_data  = m_read_data_reg;
    assign m_cursor_col = m_cursor_col_reg;
    assign m_cursor_row = m_cursor_row_reg;

    always_comb begin
        back_next = back_reg;
        fore_next = fore_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_BACK_COLOR: back_next = cfg_wdata;
                REG_FORE_COLOR: fore_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next        = state_reg;
        action_next       = action_reg;
        char_next         = char_reg;
        idx_next          = idx_reg;
        col_next          = col_reg;
        phase_next        = phase_reg;
        row_next          = row_reg;
        top_base_next     = top_base_reg;
        row_base_next     = row_base_reg;
        blank_addr_next   = blank_addr_reg;
        blank_last_next   = blank_last_reg;
        resp_data_next    = resp_data_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_read_data_next  = m_read_data_reg;
        m_cursor_col_next = m_cursor_col_reg;
        m_cursor_row_next = m_cursor_row_reg;
        s_ready           = 1'b0;
        ram_we            = 1'b0;
        ram_waddr         = blank_addr_reg;
        ram_wdata         = BLANK_CELL;
        ram_re            = 1'b0;

        case (state_reg)
            ST_INIT: begin
                ram_we = 1'b1;
                blank_addr_next = blank_addr_reg + 1'b1;
                if (blank_addr_reg == blank_last_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    action_next = action_t'(s_action);
                    char_next   = s_char_code;
                    idx_next    = s_cell_index;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                resp_data_next = '0;
                state_next = ST_RESP;
                case (action_reg)
                    ACT_PUT: begin
                        if (put_ctl.write_cell) begin
                            ram_we    = 1'b1;
                            ram_waddr = wr_addr;
                            ram_wdata = {back_reg, fore_reg, char_reg};
                        end
                        col_next   = put_col;
                        phase_next = put_phase;
                        if (put_ctl.row_inc) begin
                            row_base_next = wrap_add(row_base_reg, COL_STEP);
                            if (row_reg == ROW_LAST) begin
                                top_base_next   = wrap_add(top_base_reg, COL_STEP);
                                blank_addr_next = top_base_reg;
                                blank_last_next = top_base_reg + ROW_SPAN;
                                state_next      = ST_BLANK;
                            end else begin
                                row_next = row_reg + 1'b1;
                            end
                        end
                    end
                    ACT_CLEAR: begin
                        col_next        = '0;
                        phase_next      = '0;
                        row_next        = '0;
                        top_base_next   = '0;
                        row_base_next   = '0;
                        blank_addr_next = '0;
                        blank_last_next = LAST_CELL;
                        state_next      = ST_BLANK;
                    end
                    ACT_READ: begin
                        if (idx_in_range) begin
                            ram_re     = 1'b1;
                            state_next = ST_RDWAIT;
                        end
                    end
                    default: ;
                endcase
            end
            ST_BLANK: begin
                ram_we = 1'b1;
                blank_addr_next = blank_addr_reg + 1'b1;
                if (blank_addr_reg == blank_last_reg) begin
                    state_next = ST_RESP;
                end
            end
            ST_RDWAIT: begin
                resp_data_next = ram_rdata;
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next      = 1'b1;
                    m_read_data_next  = resp_data_reg;
                    m_cursor_col_next = col_out[COL_PORT_W-1:0];
                    m_cursor_row_next = row_out[ROW_PORT_W-1:0];
                    state_next        = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_INIT;
            col_reg        <= '0;
            phase_reg      <= '0;
            row_reg        <= '0;
            top_base_reg   <= '0;
            row_base_reg   <= '0;
            blank_addr_reg <= '0;
            blank_last_reg <= LAST_CELL;
            back_reg       <= 4'h0;
            fore_reg       <= 4'hF;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            col_reg        <= col_next;
            phase_reg      <= phase_next;
            row_reg        <= row_next;
            top_base_reg   <= top_base_next;
            row_base_reg   <= row_base_next;
            blank_addr_reg <= blank_addr_next;
            blank_last_reg <= blank_last_next;
            back_reg       <= back_next;
            fore_reg       <= fore_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        action_reg       <= action_next;
        char_reg         <= char_next;
        idx_reg          <= idx_next;
        resp_data_reg    <= resp_data_next;
        m_read_data_reg  <= m_read_data_next;
        m_cursor_col_reg <= m_cursor_col_next;
        m_cursor_row_reg <= m_cursor_row_next;
    end

endmodule

// ----- src/tcw_cell_ram.sv -----
// Cell store of the text console writer: one write port, one registered read port.
// Depends on tcw_pkg for the cell width.
`timescale 1ns / 1ps

module tcw_cell_ram
    import tcw_pkg::*;
#(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- src/tcw_cursor_unit.sv -----
// Cursor update for one put request: next column, tab phase and control flags.
// Depends on tcw_pkg for character codes and put_ctl_t.
`timescale 1ns / 1ps

module tcw_cursor_unit
    import tcw_pkg::*;
#(
    parameter int COLUMNS  = 80,
    parameter int TAB_STOP = 8,
    parameter int CW       = 7,
    parameter int PW       = 3
) (
    input  logic [CHAR_W-1:0] char_code,
    input  logic [CW-1:0]     col,
    input  logic [PW-1:0]     phase,
    output logic [CW-1:0]     next_col,
    output logic [PW-1:0]     next_phase,
    output put_ctl_t          ctl
);

    localparam int NW = $clog2(COLUMNS + TAB_STOP + 1);
    localparam logic [PW-1:0] PHASE_LAST = PW'(TAB_STOP - 1);

    logic [NW-1:0] col_w;
    logic [NW-1:0] n;
    logic [PW-1:0] ph;

    assign col_w = NW'(col);

    always_comb begin
        n = col_w;
        ph = phase;
        ctl = '0;
        case (char_code)
            CHAR_BS: begin
                if (col != '0) begin
                    n = col_w - 1'b1;
                    ph = (phase == '0) ? PHASE_LAST : phase - 1'b1;
                end
            end
            CHAR_TAB: begin
                n = col_w + NW'(TAB_STOP) - NW'(phase);
                ph = '0;
            end
            CHAR_CR: begin
                n = '0;
                ph = '0;
            end
            CHAR_LF: begin
                n = '0;
                ph = '0;
                ctl.row_inc = 1'b1;
            end
            default: begin
                if (char_code inside {[CHAR_SPACE:CHAR_DEL]}) begin
                    ctl.write_cell = 1'b1;
                    n = col_w + 1'b1;
                    ph = (phase == PHASE_LAST) ? '0 : phase + 1'b1;
                end
            end
        endcase
        if (n >= NW'(COLUMNS)) begin
            n = '0;
            ph = '0;
            ctl.row_inc = 1'b1;
        end
        next_col = CW'(n);
        next_phase = ph;
    end

endmodule

// ----- src/tcw_checker.sv -----
// Port-level checks for the text console writer, bound to the top level.
// Depends on tcw_pkg for port widths.
`timescale 1ns / 1ps

module tcw_checker
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [DATA_W-1:0]     m_read_data,
    input logic [COL_PORT_W-1:0] m_cursor_col,
    input logic [ROW_PORT_W-1:0] m_cursor_row
);

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_data)
            && $stable(m_cursor_col) && $stable(m_cursor_row))
        else $error("stalled result changed");

    a_reset_busy: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("request taken during clearing pass");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while one is at work");

    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({1'b0, m_cursor_col} < (COL_PORT_W + 1)'(COLUMNS))
            || (COLUMNS > 127))
        else $error("cursor column out of range");

    a_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({1'b0, m_cursor_row} < (ROW_PORT_W + 1)'(ROWS))
            || (ROWS > 31))
        else $error("cursor row out of range");

endmodule

bind text_console_writer tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (.*);

// ----- bench/text_console_writer_checker.sv -----
// Checker for the text console writer: watches the request, result and color
// write channels, keeps its own screen, cursor and colors, and compares results.
// Depends on tcw_pkg.
`timescale 1ns / 1ps

module text_console_writer_checker
    import tcw_pkg::*;
#(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [1:0]            s_action,
    input  logic [CHAR_W-1:0]     s_char_code,
    input  logic [IDX_W-1:0]      s_cell_index,

    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [DATA_W-1:0]     m_read_data,
    input  logic [COL_PORT_W-1:0] m_cursor_col,
    input  logic [ROW_PORT_W-1:0] m_cursor_row,

    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [COLOR_W-1:0]    cfg_wdata,

    output int                    results_owed,
    output int                    error_count,
    output int                    results_checked,
    output int                    scroll_count,
    output int                    clear_count
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam logic [COLOR_W-1:0] RESET_BACK = 4'd0;
    localparam logic [COLOR_W-1:0] RESET_FORE = 4'd15;

    typedef struct packed {
        logic [DATA_W-1:0]     read_data;
        logic [COL_PORT_W-1:0] cursor_col;
        logic [ROW_PORT_W-1:0] cursor_row;
    } console_result_t;

    logic [DATA_W-1:0]  screen [CELL_COUNT];
    int unsigned        cur_col;
    int unsigned        cur_row;
    logic [COLOR_W-1:0] back_color;
    logic [COLOR_W-1:0] fore_color;
    console_result_t    owed_q[$];
    console_result_t    want_r;

    initial begin
        error_count     = 0;
        results_checked = 0;
        scroll_count    = 0;
        clear_count     = 0;
        results_owed    = 0;
    end

    task automatic report_error(input string msg);
        $display("%0t ns text_console_writer_checker: %s", $time, msg);
        error_count++;
    endtask

    function automatic void blank_screen();
        int i;
        for (i = 0; i < CELL_COUNT; i++) begin
            screen[i] = BLANK_CELL;
        end
    endfunction

    function automatic console_result_t predict_console(
        input logic [1:0]        act,
        input logic [CHAR_W-1:0] ch,
        input logic [IDX_W-1:0]  idx
    );
        console_result_t r;
        int unsigned     pos;
        int              i;
        r.read_data = '0;
        case (act)
            ACT_PUT: begin
                if (ch == CHAR_BS) begin
                    if (cur_col != 0) cur_col--;
                end else if (ch == CHAR_TAB) begin
                    cur_col = cur_col + TAB_STOP - (cur_col % TAB_STOP);
                end else if (ch == CHAR_CR) begin
                    cur_col = 0;
                end else if (ch == CHAR_LF) begin
                    cur_col = 0;
                    cur_row++;
                end else if (ch >= CHAR_SPACE && ch <= CHAR_DEL) begin
                    pos = cur_row * COLUMNS + cur_col;
                    if (pos < CELL_COUNT) screen[pos] = {back_color, fore_color, ch};
                    cur_col++;
                end
                if (cur_col >= COLUMNS) begin
                    cur_col = 0;
                    cur_row++;
                end
                if (cur_row >= ROWS) begin
                    for (i = 0; i < (ROWS - 1) * COLUMNS; i++) begin
                        screen[i] = screen[i + COLUMNS];
                    end
                    for (i = (ROWS - 1) * COLUMNS; i < CELL_COUNT; i++) begin
                        screen[i] = BLANK_CELL;
                    end
                    cur_row = ROWS - 1;
                    scroll_count++;
                end
            end
            ACT_CLEAR: begin
                blank_screen();
                cur_col = 0;
                cur_row = 0;
                clear_count++;
            end
            ACT_READ: begin
                if (idx < CELL_COUNT) r.read_data = screen[idx];
            end
            default: begin
            end
        endcase
        r.cursor_col = cur_col[COL_PORT_W-1:0];
        r.cursor_row = cur_row[ROW_PORT_W-1:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            blank_screen();
            cur_col    = 0;
            cur_row    = 0;
            back_color = RESET_BACK;
            fore_color = RESET_FORE;
            owed_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_BACK_COLOR: back_color = cfg_wdata;
                    REG_FORE_COLOR: fore_color = cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (m_valid && m_ready) begin
                if (owed_q.size() == 0) begin
                    report_error($sformatf("result %h col %0d row %0d with no request waiting",
                        m_read_data, m_cursor_col, m_cursor_row));
                end else begin
                    want_r = owed_q.pop_front();
                    results_checked++;
                    if (m_read_data !== want_r.read_data)
                        report_error($sformatf("read_data %h, want %h",
                            m_read_data, want_r.read_data));
                    if (m_cursor_col !== want_r.cursor_col)
                        report_error($sformatf("cursor_col %0d, want %0d",
                            m_cursor_col, want_r.cursor_col));
                    if (m_cursor_row !== want_r.cursor_row)
                        report_error($sformatf("cursor_row %0d, want %0d",
                            m_cursor_row, want_r.cursor_row));
                end
            end
            if (s_valid && s_ready) begin
                owed_q.push_back(predict_console(s_action, s_char_code, s_cell_index));
            end
        end
        results_owed <= owed_q.size();
    end

endmodule

// ----- bench/text_console_writer_test.sv -----
// Top of the text console writer bench: clock, reset, request and color write
// stimulus, result sink with random stalls, and the verdict.
// Depends on tcw_pkg, text_console_writer and text_console_writer_checker.
`timescale 1ns / 1ps

module text_console_writer_test;
    import tcw_pkg::*;

    localparam int COLUMNS      = 80;
    localparam int ROWS         = 25;
    localparam int TAB_STOP     = 8;
    localparam int CELL_COUNT   = COLUMNS * ROWS;
    localparam int RESET_CYCLES = 11;
    localparam int MAX_GAP      = 12;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 50;
    localparam int HOLD_AT      = 150;
    localparam int LONG_HOLD    = 400;
    localparam int TAIL_CYCLES  = 2100;
    localparam int RUN_LIMIT_NS = 6_000_000;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_action     = ACT_PUT;
    logic [CHAR_W-1:0]     s_char_code  = '0;
    logic [IDX_W-1:0]      s_cell_index = '0;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    logic [DATA_W-1:0]     m_read_data;
    logic [COL_PORT_W-1:0] m_cursor_col;
    logic [ROW_PORT_W-1:0] m_cursor_row;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [COLOR_W-1:0]    cfg_wdata    = '0;

    int results_owed;
    int error_count;
    int results_checked;
    int scroll_count;
    int clear_count;
    int requests_sent = 0;
    bit no_idle       = 1'b0;

    always #1 aclk = ~aclk;

    text_console_writer #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_dut (.*);

    text_console_writer_checker #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_checker (.*);

    task automatic send_request(
        input action_t           act,
        input logic [CHAR_W-1:0] ch,
        input logic [IDX_W-1:0]  idx
    );
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_action     <= act;
        s_char_code  <= ch;
        s_cell_index <= idx;
        do @(posedge aclk); while (s_ready !== 1'b1);
        requests_sent++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_owed != 0 || s_ready !== 1'b1);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
    endtask

    task automatic set_colors(
        input logic [COLOR_W-1:0] back,
        input logic [COLOR_W-1:0] fore,
        input bit                 spare
    );
        wait_idle();
        cfg_write(REG_BACK_COLOR, back);
        cfg_write(REG_FORE_COLOR, fore);
        if (spare) begin
            cfg_write(REG_SPARE_LO, 4'hF);
            cfg_write(REG_SPARE_HI, 4'h0);
        end
        cfg_valid <= 1'b0;
    endtask

    // drain results with random stalls; hold off once so the block backs up
    initial begin : result_sink
        int gap;
        int taken;
        taken = 0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (taken == HOLD_AT) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            taken++;
        end
    end

    initial begin : run_limit
        #(RUN_LIMIT_NS);
        $display("text_console_writer_test: done, errors");
        $finish;
    end

    initial begin : stimulus
        action_t           act;
        logic [CHAR_W-1:0] ch;
        logic [IDX_W-1:0]  idx;
        logic [COLOR_W-1:0] back;
        logic [COLOR_W-1:0] fore;
        bit                flood;
        int                pick;
        int                p;
        int                n;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        wait_idle();

        // reset colors, field extremes, every control byte, ignored bytes
        send_request(ACT_READ,  8'h00,      11'd0);
        send_request(ACT_READ,  8'hFF,      11'd1999);
        send_request(ACT_READ,  8'h00,      11'd2000);
        send_request(ACT_READ,  8'hAA,      11'h7FF);
        send_request(ACT_PUT,   CHAR_BS,    11'd0);
        send_request(ACT_PUT,   CHAR_SPACE, 11'h7FF);
        send_request(ACT_PUT,   CHAR_DEL,   11'd0);
        send_request(ACT_PUT,   8'h00,      11'd0);
        send_request(ACT_PUT,   8'h1F,      11'd0);
        send_request(ACT_PUT,   8'h80,      11'd0);
        send_request(ACT_PUT,   8'hFF,      11'd0);
        send_request(ACT_PUT,   CHAR_BS,    11'd0);
        send_request(ACT_PUT,   CHAR_TAB,   11'd0);
        send_request(ACT_PUT,   8'h41,      11'd0);
        send_request(ACT_PUT,   CHAR_CR,    11'd0);
        send_request(ACT_PUT,   CHAR_LF,    11'd0);
        send_request(ACT_READ,  8'h00,      11'd0);
        send_request(ACT_READ,  8'h00,      11'd8);
        send_request(ACT_NONE,  8'h41,      11'd8);
        send_request(ACT_CLEAR, 8'h41,      11'd8);
        send_request(ACT_READ,  8'h00,      11'd1);

        for (p = 0; p < PHASES; p++) begin
            case (p)
                0: begin back = 4'hF; fore = 4'h0; end
                1: begin back = 4'h0; fore = 4'h0; end
                2: begin back = 4'hF; fore = 4'hF; end
                4: begin back = 4'h0; fore = 4'hF; end
                default: begin
                    back = COLOR_W'($urandom_range(0, 15));
                    fore = COLOR_W'($urandom_range(0, 15));
                end
            endcase
            set_colors(back, fore, p == 2);
            flood   = (p == 1 || p == 3);
            no_idle = (p == 4);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                ch   = CHAR_W'($urandom_range(0, 255));
                idx  = IDX_W'($urandom_range(0, 2047));
                act  = ACT_PUT;
                pick = $urandom_range(0, 99);
                if (flood) begin
                    if (pick < 40)      ch = CHAR_W'($urandom_range(CHAR_SPACE, CHAR_DEL));
                    else if (pick < 70) ch = CHAR_LF;
                    else if (pick < 85) ch = CHAR_TAB;
                    else if (pick < 90) ch = CHAR_BS;
                    else if (pick < 95) act = ACT_READ;
                    else                ch = CHAR_CR;
                end else begin
                    if (pick < 38)      ch = CHAR_W'($urandom_range(CHAR_SPACE, CHAR_DEL));
                    else if (pick < 44) ch = CHAR_LF;
                    else if (pick < 50) ch = CHAR_TAB;
                    else if (pick < 54) ch = CHAR_BS;
                    else if (pick < 57) ch = CHAR_CR;
                    else if (pick < 62) ch = CHAR_W'($urandom_range(0, 255));
                    else if (pick < 95) act = ACT_READ;
                    else if (pick < 97) act = ACT_CLEAR;
                    else                act = ACT_NONE;
                end
                if (act == ACT_READ) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 45)      idx = IDX_W'($urandom_range(CELL_COUNT - 5 * COLUMNS,
                                                                    CELL_COUNT - 1));
                    else if (pick < 90) idx = IDX_W'($urandom_range(0, CELL_COUNT - 1));
                    else                idx = IDX_W'($urandom_range(CELL_COUNT, 2047));
                end
                send_request(act, ch, idx);
            end
        end
        no_idle = 1'b0;

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("text_console_writer_test: %0d requests, %0d results compared",
            requests_sent, results_checked);
        $display("text_console_writer_test: %0d scrolls, %0d clears, %0d color settings",
            scroll_count, clear_count, PHASES);
        if (error_count == 0 && results_owed == 0) begin
            $display("text_console_writer_test: done, clean");
        end else begin
            $display("text_console_writer_test: done, errors");
        end
        $finish;
    end

endmodule
